@@ src/epwa_pkg.sv @@
// shared types and constants for the echo pulse width averager
`timescale 1ns / 1ps
`default_nettype none

package epwa_pkg;

    localparam int TIME_WIDTH = 16;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [TIME_WIDTH-1:0] capture_time;
    } in_item_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] pulse_width;
        logic [TIME_WIDTH-1:0] average_width;
    } out_item_t;

    typedef struct packed {
        logic      push;
        logic      pop;
        out_item_t data;
    } queue_ctrl_t;

endpackage

`default_nettype wire

@@ src/epwa_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module epwa_ram #(
    parameter int DATA_WIDTH = 16,
    parameter int DEPTH      = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_WIDTH-1:0]    wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/epwa_out_queue.sv @@
// two-entry result queue that decouples the update stage from the result channel
`timescale 1ns / 1ps
`default_nettype none

module epwa_out_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire epwa_pkg::queue_ctrl_t ctrl,
    output logic [1:0]                count,
    output epwa_pkg::out_item_t       head
);

    logic [1:0]          count_reg, count_next;
    epwa_pkg::out_item_t head_reg, head_next;
    epwa_pkg::out_item_t tail_reg, tail_next;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (ctrl.push && !ctrl.pop) begin
            if (count_reg == 2'd0) begin
                head_next = ctrl.data;
            end else begin
                tail_next = ctrl.data;
            end
            count_next = count_reg + 2'd1;
        end else if (!ctrl.push && ctrl.pop) begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end else if (ctrl.push && ctrl.pop) begin
            if (count_reg == 2'd1) begin
                head_next = ctrl.data;
            end else begin
                head_next = tail_reg;
                tail_next = ctrl.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign count = count_reg;
    assign head  = head_reg;

endmodule

`default_nettype wire

@@ src/echo_pulse_width_average_top.sv @@
// a falling edge accepted on s_ is registered in the update stage (s1), then in the result queue, before m_valid rises
// throughput: one transaction per cycle while s_ready is high; the ring entry is read the cycle the edge is
// taken and written back in the next, with the sum updated alongside the write
// a clear resets the ring through per-entry valid bits, no sweep
// reset: aresetn synchronous active low, clears pairing, ring position, sum and valid bits
`timescale 1ns / 1ps
`default_nettype none

module echo_pulse_width_average_top #(
    parameter int RING_DEPTH_LOG2 = 3
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire epwa_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output epwa_pkg::out_item_t      m_data
);

    localparam int TW         = epwa_pkg::TIME_WIDTH;
    localparam int RING_DEPTH = 1 << RING_DEPTH_LOG2;
    localparam int SUM_W      = TW + RING_DEPTH_LOG2;

    logic                       s_accept;
    logic                       is_clear;
    logic                       pair_ok;
    logic                       fall_hit;

    logic                       awaiting_fall_reg, awaiting_fall_next;
    logic [TW-1:0]              rise_time_reg, rise_time_next;
    logic [RING_DEPTH_LOG2-1:0] ring_pos_reg, ring_pos_next;
    logic [SUM_W-1:0]           width_sum_reg, width_sum_next;
    logic [RING_DEPTH-1:0]      entry_valid_reg, entry_valid_next;

    logic                       s1_valid_reg, s1_valid_next;
    logic [TW-1:0]              s1_width_reg, s1_width_next;
    logic [RING_DEPTH_LOG2-1:0] s1_pos_reg, s1_pos_next;

    logic [TW-1:0]              ram_rdata;
    logic [TW-1:0]              oldest;
    logic [SUM_W-1:0]           sum_update;

    epwa_pkg::queue_ctrl_t      q_ctrl;
    logic [1:0]                 q_count;

    assign s_accept = s_valid && s_ready;
    assign is_clear = (s_data.op == epwa_pkg::OP_CLEAR);
    assign pair_ok  = (s_data.capture_time >= rise_time_reg);
    assign fall_hit = s_accept && !is_clear && awaiting_fall_reg && pair_ok;

    // room is reserved for the result that may still be in the update stage
    assign s_ready = (q_count == 2'd0) || ((q_count == 2'd1) && !s1_valid_reg);

    // entries never written since the last clear read as zero
    assign oldest     = entry_valid_reg[s1_pos_reg] ? ram_rdata : '0;
    assign sum_update = width_sum_reg - {{RING_DEPTH_LOG2{1'b0}}, oldest}
                      + {{RING_DEPTH_LOG2{1'b0}}, s1_width_reg};

    always_comb begin
        awaiting_fall_next = awaiting_fall_reg;
        rise_time_next     = rise_time_reg;
        ring_pos_next      = ring_pos_reg;
        width_sum_next     = width_sum_reg;
        entry_valid_next   = entry_valid_reg;
        s1_valid_next      = 1'b0;
        s1_width_next      = s1_width_reg;
        s1_pos_next        = s1_pos_reg;

        if (s1_valid_reg) begin
            width_sum_next               = sum_update;
            entry_valid_next[s1_pos_reg] = 1'b1;
        end

        if (s_accept) begin
            if (is_clear) begin
                // a later clear wins over the write-back of an earlier edge
                awaiting_fall_next = 1'b0;
                ring_pos_next      = '0;
                width_sum_next     = '0;
                entry_valid_next   = '0;
            end else if (!awaiting_fall_reg) begin
                rise_time_next     = s_data.capture_time;
                awaiting_fall_next = 1'b1;
            end else begin
                awaiting_fall_next = 1'b0;
                if (pair_ok) begin
                    s1_valid_next = 1'b1;
                    s1_width_next = s_data.capture_time - rise_time_reg;
                    s1_pos_next   = ring_pos_reg;
                    ring_pos_next = ring_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_fall_reg <= 1'b0;
            rise_time_reg     <= '0;
            ring_pos_reg      <= '0;
            width_sum_reg     <= '0;
            entry_valid_reg   <= '0;
            s1_valid_reg      <= 1'b0;
        end else begin
            awaiting_fall_reg <= awaiting_fall_next;
            rise_time_reg     <= rise_time_next;
            ring_pos_reg      <= ring_pos_next;
            width_sum_reg     <= width_sum_next;
            entry_valid_reg   <= entry_valid_next;
            s1_valid_reg      <= s1_valid_next;
        end
        s1_width_reg <= s1_width_next;
        s1_pos_reg   <= s1_pos_next;
    end

    epwa_ram #(
        .DATA_WIDTH (TW),
        .DEPTH      (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_pos_reg),
        .wdata (s1_width_reg),
        .re    (fall_hit),
        .raddr (ring_pos_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        q_ctrl.push               = s1_valid_reg;
        q_ctrl.pop                = m_valid && m_ready;
        q_ctrl.data.pulse_width   = s1_width_reg;
        q_ctrl.data.average_width = sum_update[SUM_W-1:RING_DEPTH_LOG2];
    end

    epwa_out_queue u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .count   (q_count),
        .head    (m_data)
    );

    assign m_valid = (q_count != 2'd0);

    // the update stage only runs for a falling edge taken the cycle before
    a_s1_from_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s1_valid_reg) |-> $past(fall_hit))
        else $error("update stage started without a falling edge");

    // falling edges alternate with other transactions, so updates never run back to back
    a_s1_spaced: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |=> !s1_valid_reg)
        else $error("two ring updates in consecutive cycles");

    // a clear leaves the averager empty
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_clear) |=>
            (width_sum_reg == '0 && ring_pos_reg == '0 && entry_valid_reg == '0
             && !awaiting_fall_reg))
        else $error("clear did not empty the averager");

    // the queue is never pushed while full and not draining
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (q_count != 2'd2 || (m_valid && m_ready)))
        else $error("result queue overflow");

endmodule

`default_nettype wire

@@ verif/tb_echo_pulse_width_average_top.sv @@
// testbench for the echo pulse width averager: random handshakes, scoreboard with its own ring model
`timescale 1ns / 1ps

module tb_echo_pulse_width_average_top;

    localparam int TIME_WIDTH = epwa_pkg::TIME_WIDTH;
    localparam int AVG_LOG2  = 3;
    localparam int AVG_DEPTH = 1 << AVG_LOG2;
    localparam int SUM_WIDTH = TIME_WIDTH + AVG_LOG2;
    localparam int RANDOM_ITEMS = 1100;

    // scoreboard: tracks edge pairing and the width ring, queues the results it predicts
    class pulse_avg_scoreboard;
        logic                  waiting_fall;
        logic [TIME_WIDTH-1:0] rise_stamp;
        logic [TIME_WIDTH-1:0] width_ring [AVG_DEPTH];
        logic [AVG_LOG2-1:0]   slot;
        logic [SUM_WIDTH-1:0]  width_total;
        epwa_pkg::out_item_t   expected_results [$];
        int errors;
        int inputs_seen;
        int results_checked;
        int drops;
        int clears;

        function new();
            errors = 0;
            inputs_seen = 0;
            results_checked = 0;
            drops = 0;
            clears = 0;
            rise_stamp = '0;
            clear_ring();
        endfunction

        function void clear_ring();
            foreach (width_ring[i]) width_ring[i] = '0;
            slot = '0;
            width_total = '0;
            waiting_fall = 1'b0;
        endfunction

        function void note_capture(epwa_pkg::in_item_t item);
            logic [TIME_WIDTH-1:0] width;
            epwa_pkg::out_item_t   res;
            inputs_seen++;
            if (item.op == epwa_pkg::OP_CLEAR) begin
                clears++;
                clear_ring();
                return;
            end
            if (!waiting_fall) begin
                rise_stamp = item.capture_time;
                waiting_fall = 1'b1;
                return;
            end
            waiting_fall = 1'b0;
            // falling edge earlier than the rising edge: pair thrown away
            if (item.capture_time < rise_stamp) begin
                drops++;
                return;
            end
            width = item.capture_time - rise_stamp;
            width_total = width_total - SUM_WIDTH'(width_ring[slot]) + SUM_WIDTH'(width);
            width_ring[slot] = width;
            slot = slot + 1'b1;
            res.pulse_width = width;
            res.average_width = width_total[SUM_WIDTH-1:AVG_LOG2];
            expected_results.push_back(res);
        endfunction

        function void check_result(epwa_pkg::out_item_t got);
            epwa_pkg::out_item_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result width=%0d avg=%0d",
                         $time, got.pulse_width, got.average_width);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (got.pulse_width !== want.pulse_width) begin
                $display("%0t: pulse_width mismatch expected=%0d actual=%0d",
                         $time, want.pulse_width, got.pulse_width);
                errors++;
            end
            if (got.average_width !== want.average_width) begin
                $display("%0t: average_width mismatch expected=%0d actual=%0d",
                         $time, want.average_width, got.average_width);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void report_leftover();
            if (expected_results.size() != 0) begin
                $display("%0t: %0d expected results never arrived",
                         $time, expected_results.size());
                errors++;
            end
        endfunction
    endclass

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    epwa_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    epwa_pkg::out_item_t m_data;

    pulse_avg_scoreboard sb;
    bit burst_mode = 1'b0;
    int items_sent = 0;
    int out_stall  = 0;

    echo_pulse_width_average_top #(
        .RING_DEPTH_LOG2(AVG_LOG2)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (out_stall > 0) begin
            m_ready <= 1'b0;
            out_stall--;
        end else if (!burst_mode && $urandom_range(0, 99) < 25) begin
            out_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(7, 39);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor both channels at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_capture(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    task automatic send_item(logic op, logic [TIME_WIDTH-1:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.op <= op;
        s_data.capture_time <= t;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_pair(logic [TIME_WIDTH-1:0] rise, logic [TIME_WIDTH-1:0] fall);
        send_item(epwa_pkg::OP_CAPTURE, rise);
        send_item(epwa_pkg::OP_CAPTURE, fall);
    endtask

    task automatic run_random();
        int kind;
        int r;
        int span;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent % 64 < 2) burst_mode = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                r = $urandom_range(0, 65535);
                span = 65535 - r;
                if ($urandom_range(0, 1) && span > 200) span = 200;
                send_pair(TIME_WIDTH'(r), TIME_WIDTH'(r + $urandom_range(0, span)));
            end else if (kind < 84) begin
                r = $urandom_range(1, 65535);
                send_pair(TIME_WIDTH'(r), TIME_WIDTH'($urandom_range(0, r - 1)));
            end else if (kind < 89) begin
                // clear, sometimes with a rising edge still open
                if ($urandom_range(0, 1)) begin
                    send_item(epwa_pkg::OP_CAPTURE, TIME_WIDTH'($urandom));
                end
                send_item(epwa_pkg::OP_CLEAR, TIME_WIDTH'($urandom));
            end else begin
                send_item(epwa_pkg::OP_CAPTURE, TIME_WIDTH'($urandom));
            end
        end
    endtask

    initial begin
        int waited;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, equal times, reversed pair, clear mid pair, ring wrap at max
        send_item(epwa_pkg::OP_CLEAR, 16'hFFFF);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'd100, 16'd99);
        send_item(epwa_pkg::OP_CAPTURE, 16'd500);
        send_item(epwa_pkg::OP_CLEAR, 16'h0000);
        send_pair(16'd200, 16'd700);
        repeat (AVG_DEPTH) send_pair(16'h0000, 16'hFFFF);

        run_random();
        s_valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (16) @(posedge aclk);
        sb.report_leftover();

        $display("run covered %0d transactions in and %0d results checked",
                 sb.inputs_seen, sb.results_checked);
        $display("including %0d reversed pairs dropped and %0d clears", sb.drops, sb.clears);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
